// ===== design/prru_pkg.sv =====
package prru_pkg;

  localparam int PERM_LEN = 9;
  localparam int RANK_W   = 19;
  localparam int ELEM_W   = 4;
  localparam int DIGIT_W  = 4;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // 9! -- first rank that does not name a permutation
  localparam rank_t RANK_LIMIT = 19'd362880;

  typedef enum logic {
    CMD_RANK   = 1'b0,
    CMD_UNRANK = 1'b1
  } cmd_t;

  // One pipeline slot. In rank mode acc is the running sum and elems hold the
  // input permutation; in unrank mode acc is the remaining rank, elems fill up
  // with picked values and used marks the values already taken.
  typedef struct packed {
    cmd_t                       cmd;
    logic                       err;
    rank_t                      acc;
    elem_t [PERM_LEN-1:0]       elems;
    logic  [PERM_LEN:1]         used;
  } stage_t;

  function automatic rank_t fact(input int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) begin
      f = f * k;
    end
    return rank_t'(f);
  endfunction

endpackage

// ===== design/permutation_rank_unrank.sv =====
// Permutation rank / unrank over the values 1 to 9 (Lehmer code).
//
// Command channel: drive command, rank_in and elem_in_0..8 with start high;
// the item is taken at a rising edge where start is high and busy is low.
// busy stays low, so an item can be taken at every edge.
// command = rank: rank_out returns the lexicographic rank of the elements.
// command = unrank: elem_out_0..8 return the permutation for rank_in; a rank
// of 9! or more raises range_error and returns all-zero elements.
// Result channel: done is high for exactly one cycle with the result fields;
// the result is taken at the edge that ends that cycle and cannot be held off.
// An item taken at an edge passes through the input register and the stages
// below into the result register. Throughput: one item per cycle.
// The path is set by the nine-stage pipeline behind the input register, one
// stage per element position: each stage adds one weighted count (rank) or
// peels one factorial digit and picks one unused value (unrank).
// Reset (rst, synchronous) drops every item in flight; no result follows.
module permutation_rank_unrank (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            command,
  input  prru_pkg::rank_t rank_in,
  input  prru_pkg::elem_t elem_in_0,
  input  prru_pkg::elem_t elem_in_1,
  input  prru_pkg::elem_t elem_in_2,
  input  prru_pkg::elem_t elem_in_3,
  input  prru_pkg::elem_t elem_in_4,
  input  prru_pkg::elem_t elem_in_5,
  input  prru_pkg::elem_t elem_in_6,
  input  prru_pkg::elem_t elem_in_7,
  input  prru_pkg::elem_t elem_in_8,
  output logic            done,
  output prru_pkg::rank_t rank_out,
  output prru_pkg::elem_t elem_out_0,
  output prru_pkg::elem_t elem_out_1,
  output prru_pkg::elem_t elem_out_2,
  output prru_pkg::elem_t elem_out_3,
  output prru_pkg::elem_t elem_out_4,
  output prru_pkg::elem_t elem_out_5,
  output prru_pkg::elem_t elem_out_6,
  output prru_pkg::elem_t elem_out_7,
  output prru_pkg::elem_t elem_out_8,
  output logic            range_error
);
  import prru_pkg::*;

  // Valid bit per slot: slot 0 is the input register, slot PERM_LEN the
  // result register.
  logic   [PERM_LEN:0] vld;
  stage_t              pipe [PERM_LEN+1];
  stage_t              in_next;
  logic                accept;
  elem_t  [PERM_LEN-1:0] elems_out;

  // No multi-cycle work anywhere, so never push back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Build the input slot: rank mode carries the elements, unrank mode the
  // rank, an out-of-range rank only its error flag.
  always_comb begin
    in_next     = '0;
    in_next.cmd = cmd_t'(command);
    if (cmd_t'(command) == CMD_RANK) begin
      in_next.elems = {elem_in_8, elem_in_7, elem_in_6, elem_in_5, elem_in_4,
                       elem_in_3, elem_in_2, elem_in_1, elem_in_0};
    end else if (rank_in >= RANK_LIMIT) begin
      in_next.err = 1'b1;
    end else begin
      in_next.acc = rank_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PERM_LEN-1:0], accept};
    end
  end

  // Hold the input register while no item arrives.
  always_ff @(posedge clk) begin
    if (accept) begin
      pipe[0] <= in_next;
    end
  end

  // One stage per position s, weight (8-s)!.
  for (genvar s = 0; s < PERM_LEN; s++) begin : g_stage
    localparam rank_t W = fact(PERM_LEN - 1 - s);

    stage_t cur;
    stage_t nxt;
    digit_t cnt;
    digit_t digit;
    digit_t seen;
    logic   found;

    assign cur = pipe[s];

    always_comb begin
      nxt   = cur;
      cnt   = '0;
      digit = '0;
      seen  = '0;
      found = 1'b0;

      // Rank: later elements smaller than this one.
      for (int j = 0; j < PERM_LEN; j++) begin
        if (j > s && cur.elems[j] < cur.elems[s]) begin
          cnt = cnt + digit_t'(1);
        end
      end

      // Unrank: factorial digit by parallel compares against the multiples.
      for (int k = 1; k < PERM_LEN; k++) begin
        if (cur.acc >= rank_t'(W * rank_t'(k))) begin
          digit = digit + digit_t'(1);
        end
      end

      case (cur.cmd)
        CMD_RANK: begin
          nxt.acc = cur.acc + rank_t'(W * rank_t'(cnt));
        end
        CMD_UNRANK: begin
          nxt.acc = cur.acc - rank_t'(W * rank_t'(digit));
          // Take the digit-th unused value, counting from zero.
          for (int v = 1; v <= PERM_LEN; v++) begin
            if (!cur.used[v] && !found) begin
              if (seen == digit) begin
                found         = 1'b1;
                nxt.elems[s]  = elem_t'(v);
                nxt.used[v]   = 1'b1;
              end else begin
                seen = seen + digit_t'(1);
              end
            end
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      pipe[s+1] <= nxt;
    end
  end

  // Drive the result from the last slot; drop the fields the mode does not own.
  assign done        = vld[PERM_LEN];
  assign range_error = pipe[PERM_LEN].err;
  assign rank_out    = (pipe[PERM_LEN].cmd == CMD_RANK) ? pipe[PERM_LEN].acc : '0;
  assign elems_out   = (pipe[PERM_LEN].cmd == CMD_UNRANK && !pipe[PERM_LEN].err) ?
                       pipe[PERM_LEN].elems : '0;

  assign elem_out_0 = elems_out[0];
  assign elem_out_1 = elems_out[1];
  assign elem_out_2 = elems_out[2];
  assign elem_out_3 = elems_out[3];
  assign elem_out_4 = elems_out[4];
  assign elem_out_5 = elems_out[5];
  assign elem_out_6 = elems_out[6];
  assign elem_out_7 = elems_out[7];
  assign elem_out_8 = elems_out[8];

`ifndef SYNTHESIS
  // Every accepted item comes out exactly after the pipeline depth.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(PERM_LEN+1) done)
    else $error("item accepted but no result after pipeline latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PERM_LEN+1))
    else $error("result shown without a matching accepted item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && range_error |-> rank_out == '0 && elems_out == '0 &&
      cmd_t'($past(command, PERM_LEN+1)) == CMD_UNRANK)
    else $error("range error with nonzero fields or outside unrank");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rank_out < RANK_LIMIT)
    else $error("rank sum overflowed 9!");
`endif

endmodule
